// ===== sv/bns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest scaler package
// Widths, reset values, request and response types, and the sequencer states
// that the scaler's modules share.
// ----------------------------------------------------------------------------
package bns_pkg;

   // Default size of the byte store.
   localparam int MEM_BYTES_DEFAULT = 131072;

   // Field widths.
   localparam int KIND_W    = 2;
   localparam int OFFSET_W  = 17;
   localparam int BYTE_W    = 8;
   localparam int COORD_W   = 10;
   localparam int PIXEL_W   = 16;
   localparam int DIM_W     = 11;

   // Datapath widths.
   localparam int PITCH_W     = 13;
   localparam int ROW_PROD_W  = DIM_W + PITCH_W;
   localparam int DIV_NUM_W   = 22;
   localparam int ADDR_CALC_W = 27;

   // Configuration port widths.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(54);
   localparam logic [DIM_W-1:0]    DIM_RESET    = DIM_W'(64);
   localparam logic [PITCH_W-1:0]  PITCH_RESET  = PITCH_W'(((64 * 3 + 3) / 4) * 4);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] byte_address;
      logic [BYTE_W-1:0]   byte_value;
      logic [COORD_W-1:0]  dest_x;
      logic [COORD_W-1:0]  dest_y;
      logic [COORD_W-1:0]  src_x;
      logic [COORD_W-1:0]  src_y;
      logic [PIXEL_W-1:0]  pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_565;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] pix_offset;
      logic [DIM_W-1:0]    src_width;
      logic [DIM_W-1:0]    src_height;
      logic [DIM_W-1:0]    dst_width;
      logic [DIM_W-1:0]    dst_height;
      logic [PITCH_W-1:0]  row_pitch;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL,
      ST_ADDR,
      ST_RD_B,
      ST_RD_G,
      ST_RD_R,
      ST_RD_END,
      ST_WR_B,
      ST_WR_G,
      ST_WR_R
   } state_type;

endpackage

// ===== sv/bmp_nearest_scaler_rgb565.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor RGB565 scaler over a stored 24-bit BMP
// Holds a bottom-up BMP in a byte store, maps destination pixels to source
// pixels and packs them as RGB565, and writes RGB565 pixels back.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; results appear on
// rsp_data for one cycle with rsp_strobe and cannot be held off. A byte load
// (and the unused kind) is absorbed in its accept cycle, so these can come
// every cycle. A scaled-pixel read keeps busy high through the divider start,
// the two parallel dividers (two quotient bits per cycle over a 22-bit
// numerator), the row multiply and address add, and the three byte reads
// through the store's single read port; no other request is taken until its
// result. A pixel write is busy through the multiply, the address add and
// the three byte writes. When the address falls outside the store, the
// result comes right after the address step. The store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module bmp_nearest_scaler_rgb565
   import bns_pkg::*;
#(
   parameter int  MEM_BYTES = MEM_BYTES_DEFAULT,
   localparam int AddrW     = $clog2(MEM_BYTES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type                cfg;
   state_type              state_ff;
   state_type              state_in;
   req_type                req_ff;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;
   logic                   rsp_strobe_ff;
   logic                   rsp_strobe_in;
   logic                   accept;

   logic                   div_start;
   logic [DIV_NUM_W-1:0]   num_x;
   logic [DIV_NUM_W-1:0]   num_y;
   logic [DIM_W-1:0]       den_x;
   logic [DIM_W-1:0]       den_y;
   logic                   div_done_x;
   logic                   div_done_y;
   logic [DIV_NUM_W-1:0]   quo_x;
   logic [DIV_NUM_W-1:0]   quo_y;

   logic [DIV_NUM_W-1:0]   sx_sel;
   logic [DIV_NUM_W-1:0]   sy_sel;
   logic [DIM_W-1:0]       row_val;
   logic                   row_neg;
   logic [ADDR_CALC_W-1:0] sx_x3;
   logic [ADDR_CALC_W-1:0] base_in;
   logic [ROW_PROD_W-1:0]  prod_ff;
   logic [ADDR_CALC_W-1:0] base_ff;
   logic                   row_neg_ff;
   logic [ADDR_CALC_W-1:0] addr_sum;
   logic                   addr_oor;
   logic [AddrW-1:0]       addr_ff;
   logic [BYTE_W-1:0]      b_ff;
   logic [BYTE_W-1:0]      g_ff;

   logic [ADDR_CALC_W-1:0] load_addr;
   logic                   load_ok;
   logic                   mem_we;
   logic [AddrW-1:0]       mem_waddr;
   logic [BYTE_W-1:0]      mem_wdata;
   logic                   mem_re;
   logic [AddrW-1:0]       mem_raddr;
   logic [BYTE_W-1:0]      mem_rdata;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Configuration registers.
   bns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Scale numerators; a zero destination size divides by one.
   always_comb begin
      num_x = DIV_NUM_W'(req_ff.dest_x) * DIV_NUM_W'(cfg.src_width);
      num_y = DIV_NUM_W'(req_ff.dest_y) * DIV_NUM_W'(cfg.src_height);
      den_x = (cfg.dst_width == '0) ? DIM_W'(1) : cfg.dst_width;
      den_y = (cfg.dst_height == '0) ? DIM_W'(1) : cfg.dst_height;
   end

   bns_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num_x),
      .divisor   (den_x),
      .done      (div_done_x),
      .quotient  (quo_x)
   );

   bns_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num_y),
      .divisor   (den_y),
      .done      (div_done_y),
      .quotient  (quo_y)
   );

   // Byte store.
   bns_store #(
      .MEM_BYTES (MEM_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Source coordinate, bottom-up row and column offset for the address step.
   always_comb begin
      if (req_ff.kind == KIND_READ) begin
         sx_sel = quo_x;
         sy_sel = quo_y;
      end else begin
         sx_sel = DIV_NUM_W'(req_ff.src_x);
         sy_sel = DIV_NUM_W'(req_ff.src_y);
      end
      row_neg = sy_sel >= DIV_NUM_W'(cfg.src_height);
      row_val = cfg.src_height - DIM_W'(1) - sy_sel[DIM_W-1:0];
      sx_x3   = ADDR_CALC_W'(sx_sel) + {ADDR_CALC_W'(sx_sel) << 1};
      base_in = ADDR_CALC_W'(cfg.pix_offset) + sx_x3;
   end

   // Address of the pixel's blue byte and the store bound check.
   always_comb begin
      addr_sum = base_ff + ADDR_CALC_W'(prod_ff);
      addr_oor = row_neg_ff || (addr_sum > ADDR_CALC_W'(MEM_BYTES - 3));
   end

   // Byte load bound check.
   always_comb begin
      load_addr = ADDR_CALC_W'(req_data.byte_address);
      load_ok   = load_addr < ADDR_CALC_W'(MEM_BYTES);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_READ) begin
               state_in = ST_LOAD;
            end else if (accept && req_data.kind == KIND_WRITE) begin
               state_in = ST_MUL;
            end
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done_x && div_done_y) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ADDR;
         ST_ADDR: begin
            if (addr_oor) begin
               state_in = ST_IDLE;
            end else if (req_ff.kind == KIND_READ) begin
               state_in = ST_RD_B;
            end else begin
               state_in = ST_WR_B;
            end
         end
         ST_RD_B:   state_in = ST_RD_G;
         ST_RD_G:   state_in = ST_RD_R;
         ST_RD_R:   state_in = ST_RD_END;
         ST_RD_END: state_in = ST_IDLE;
         ST_WR_B:   state_in = ST_WR_G;
         ST_WR_G:   state_in = ST_WR_R;
         ST_WR_R:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Store accesses, divider start and the response.
   always_comb begin
      div_start     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            mem_we    = accept && (req_data.kind == KIND_LOAD) && load_ok;
            mem_waddr = load_addr[AddrW-1:0];
            mem_wdata = req_data.byte_value;
         end
         ST_LOAD: begin
            div_start = 1'b1;
         end
         ST_ADDR: begin
            if (addr_oor) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.out_of_range = 1'b1;
            end
         end
         ST_RD_B: begin
            mem_re = 1'b1;
         end
         ST_RD_G: begin
            mem_re    = 1'b1;
            mem_raddr = addr_ff + AddrW'(1);
         end
         ST_RD_R: begin
            mem_re    = 1'b1;
            mem_raddr = addr_ff + AddrW'(2);
         end
         ST_RD_END: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.pixel_565 = {mem_rdata[7:3], g_ff[7:2], b_ff[7:3]};
         end
         ST_WR_B: begin
            mem_we    = 1'b1;
            mem_wdata = {req_ff.pixel_in[4:0], 3'b000};
         end
         ST_WR_G: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff + AddrW'(1);
            mem_wdata = {req_ff.pixel_in[10:5], 2'b00};
         end
         ST_WR_R: begin
            mem_we        = 1'b1;
            mem_waddr     = addr_ff + AddrW'(2);
            mem_wdata     = {req_ff.pixel_in[15:11], 3'b000};
            rsp_strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         req_ff <= req_data;
      end
      case (state_ff)
         ST_MUL: begin
            prod_ff    <= ROW_PROD_W'(row_val) * ROW_PROD_W'(cfg.row_pitch);
            base_ff    <= base_in;
            row_neg_ff <= row_neg;
         end
         ST_ADDR: begin
            addr_ff <= addr_sum[AddrW-1:0];
         end
         ST_RD_G: begin
            b_ff <= mem_rdata;
         end
         ST_RD_R: begin
            g_ff <= mem_rdata;
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTHESIS
   // A result lasts one cycle and never comes back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // Every read or write request that made the block busy ends with a result.
   a_busy_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without a response");

   // Both dividers run in lockstep.
   a_dividers_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_done_x == div_done_y)
      else $error("coordinate dividers out of step");

   // An access outside the store reports a zero pixel.
   a_oor_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.out_of_range |-> rsp_data.pixel_565 == '0)
      else $error("out-of-range response carries pixel data");
`endif

endmodule

// ===== sv/bns_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest scaler configuration registers
// APB-style register file for the image geometry; also keeps the padded
// row pitch of the source image up to date.
// ----------------------------------------------------------------------------
module bns_csr
   import bns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam int IdxW = CSR_ADDR_W - 2;

   localparam logic [IdxW-1:0] REG_OFFSET     = IdxW'(0);
   localparam logic [IdxW-1:0] REG_SRC_WIDTH  = IdxW'(1);
   localparam logic [IdxW-1:0] REG_SRC_HEIGHT = IdxW'(2);
   localparam logic [IdxW-1:0] REG_DST_WIDTH  = IdxW'(3);
   localparam logic [IdxW-1:0] REG_DST_HEIGHT = IdxW'(4);

   cfg_type              cfg_ff;
   logic [IdxW-1:0]      reg_idx;
   logic                 wr_fire;
   logic [DIM_W-1:0]     wr_width;
   logic [PITCH_W-1:0]   width_x3;
   logic [PITCH_W-1:0]   pitch_sum;
   logic [PITCH_W-1:0]   pitch_in;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_fire = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   // Row pitch is three bytes per pixel, rounded up to a multiple of four.
   always_comb begin
      wr_width  = pwdata[DIM_W-1:0];
      width_x3  = PITCH_W'(wr_width) + {PITCH_W'(wr_width) << 1};
      pitch_sum = width_x3 + PITCH_W'(3);
      pitch_in  = {pitch_sum[PITCH_W-1:2], 2'b00};
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pix_offset <= OFFSET_RESET;
         cfg_ff.src_width  <= DIM_RESET;
         cfg_ff.src_height <= DIM_RESET;
         cfg_ff.dst_width  <= DIM_RESET;
         cfg_ff.dst_height <= DIM_RESET;
         cfg_ff.row_pitch  <= PITCH_RESET;
      end else if (wr_fire) begin
         case (reg_idx)
            REG_OFFSET: begin
               cfg_ff.pix_offset <= pwdata[OFFSET_W-1:0];
            end
            REG_SRC_WIDTH: begin
               cfg_ff.src_width <= wr_width;
               cfg_ff.row_pitch <= pitch_in;
            end
            REG_SRC_HEIGHT: begin
               cfg_ff.src_height <= pwdata[DIM_W-1:0];
            end
            REG_DST_WIDTH: begin
               cfg_ff.dst_width <= pwdata[DIM_W-1:0];
            end
            REG_DST_HEIGHT: begin
               cfg_ff.dst_height <= pwdata[DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (reg_idx)
         REG_OFFSET:     prdata = CSR_DATA_W'(cfg_ff.pix_offset);
         REG_SRC_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_DST_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.dst_width);
         REG_DST_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.dst_height);
         default:        prdata = '0;
      endcase
   end

endmodule

// ===== sv/bns_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest scaler divider
// Restoring unsigned divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module bns_divider
   import bns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numerator,
   input  logic [DIM_W-1:0]     divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   localparam int Steps = DIV_NUM_W / 2;
   localparam int CntW  = $clog2(Steps);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_NUM_W-1:0] quo_in;
   logic [DIM_W-1:0]     rem_ff;
   logic [DIM_W-1:0]     den_ff;
   logic [CntW-1:0]      cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DIM_W:0]       trial1;
   logic [DIM_W:0]       rem1;
   logic [DIM_W:0]       trial2;
   logic [DIM_W:0]       rem2;
   logic                 bit1;
   logic                 bit2;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Two dependent shift-and-subtract steps; the remainder stays below the divisor.
   always_comb begin
      trial1 = {rem_ff, quo_ff[DIV_NUM_W-1]};
      bit1   = trial1 >= {1'b0, den_ff};
      rem1   = bit1 ? trial1 - {1'b0, den_ff} : trial1;
      trial2 = {rem1[DIM_W-1:0], quo_ff[DIV_NUM_W-2]};
      bit2   = trial2 >= {1'b0, den_ff};
      rem2   = bit2 ? trial2 - {1'b0, den_ff} : trial2;
      quo_in = {quo_ff[DIV_NUM_W-3:0], bit1, bit2};
   end

   // Control: step counter and status.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(Steps - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: the quotient shifts in where the numerator shifts out.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem2[DIM_W-1:0];
      end
   end

endmodule

// ===== sv/bns_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest scaler byte store
// Single-clock byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bns_store
   import bns_pkg::*;
#(
   parameter int  MEM_BYTES = MEM_BYTES_DEFAULT,
   localparam int AddrW     = $clog2(MEM_BYTES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AddrW-1:0]  wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [MEM_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
